// ----- rtl/tap_pkg.sv -----
// package for the totalizer: field widths, codes and shared structs
`default_nettype none

package tap_pkg;

  localparam int unsigned INC_BITS      = 32;
  localparam int unsigned OUT_SUM_BITS  = 48;
  localparam int unsigned BUCKET_BITS   = 34;
  localparam int unsigned TIMER_BITS    = 16;
  localparam int unsigned THRESH_BITS   = 32;
  localparam int unsigned COUNT_BITS    = 32;
  localparam int unsigned IN_DATA_BITS  = 72;
  localparam int unsigned OUT_DATA_BITS = 136;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [TIMER_BITS-1:0] PULSE_WIDTH_RESET = 16'd100;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BUCKET_THRESHOLD = 1'b0,
    REG_PULSE_WIDTH      = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [THRESH_BITS-1:0] threshold;
    logic [TIMER_BITS-1:0]  width;
  } pulse_cfg_t;

  typedef struct packed {
    logic [BUCKET_BITS-1:0] bucket;
    logic                   level;
    logic [TIMER_BITS-1:0]  elapsed;
    logic [COUNT_BITS-1:0]  tally;
  } pulse_state_t;

  typedef struct packed {
    action_t             action;
    logic [INC_BITS-1:0] local_inc;
    logic                clear;
  } pulse_item_t;

endpackage

`default_nettype wire

// ----- rtl/tap_pulse.sv -----
// bucket, pulse timer and pulse counter update for one item
`default_nettype none

module tap_pulse (
  input  tap_pkg::pulse_cfg_t   cfg,
  input  tap_pkg::pulse_state_t state,
  input  tap_pkg::pulse_item_t  item,
  output tap_pkg::pulse_state_t state_next,
  output logic                  started
);
  import tap_pkg::*;

  logic [BUCKET_BITS:0]   bucket_sum;
  logic [BUCKET_BITS-1:0] bucket_fill;
  logic [BUCKET_BITS-1:0] thresh_ext;
  logic [TIMER_BITS-1:0]  elapsed_step;
  logic                   level_step;

  assign thresh_ext = BUCKET_BITS'(cfg.threshold);
  assign bucket_sum = (BUCKET_BITS+1)'(state.bucket) + (BUCKET_BITS+1)'(item.local_inc);

  always_comb begin
    bucket_fill = bucket_sum[BUCKET_BITS] ? '1 : bucket_sum[BUCKET_BITS-1:0];
    if (item.clear) begin
      bucket_fill = '0;
    end
  end

  always_comb begin
    state_next   = state;
    started      = 1'b0;
    elapsed_step = state.elapsed;
    level_step   = state.level;
    if (item.action == ACT_ADD) begin
      state_next.bucket = bucket_fill;
      if (bucket_fill >= thresh_ext) begin
        state_next.bucket = bucket_fill - thresh_ext;
        level_step        = 1'b1;
        elapsed_step      = '0;
        state_next.tally  = state.tally + COUNT_BITS'(1);
        started           = 1'b1;
      end
    end else begin
      // timer sticks at its top value
      if (state.elapsed != '1) begin
        elapsed_step = state.elapsed + TIMER_BITS'(1);
      end
    end
    state_next.elapsed = elapsed_step;
    state_next.level   = level_step && (elapsed_step < cfg.width);
  end

endmodule

`default_nettype wire

// ----- rtl/totalizer_accumulate_pulse.sv -----
// top level of the weighing totalizer with pulse output
`default_nettype none

// Weighing totalizer with pulse output. Each input item is either an add
// (action 0: local and master increments in 16.16 fixed point, plus an
// optional bucket clear) or a one millisecond tick (action 1). Every item
// gives exactly one result item carrying both saturating 32.16 totals, the
// pulse level, a flag for a newly raised pulse and the wrapping pulse count.
// The block takes one item per clock cycle while the result stream is not
// stalled: the item is captured in an input register, then the totals,
// bucket and timer update in one pass of add, compare and subtract logic
// into the state and result registers, from which the result is valid.
// With m_tready high one item goes in and one comes out every
// cycle. While a result waits the input register still takes one item;
// after that s_tready follows m_tready. Configuration writes (threshold,
// pulse width) are taken at any edge with cfg_wen high and should only
// happen while the block is idle.
module totalizer_accumulate_pulse #(
  parameter int unsigned TOTAL_BITS    = 48,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input stream
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // [31:0] local_increment, [63:32] master_increment, [64] clear_bucket
  input  wire logic [tap_pkg::IN_DATA_BITS-1:0]     s_tdata,
  // [0] action
  input  wire logic                                 s_tuser,
  // result stream
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // [47:0] local_sum, [95:48] master_sum, [96] pulse_out,
  // [97] pulse_started, [129:98] pulses_sent
  output logic [tap_pkg::OUT_DATA_BITS-1:0]         m_tdata,
  // configuration write port
  input  wire logic                                 cfg_wen,
  input  wire logic [tap_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [tap_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import tap_pkg::*;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(64'd1 << FRACTION_BITS);

  // configuration registers
  pulse_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESH_RESET;
      cfg.width     <= PULSE_WIDTH_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BUCKET_THRESHOLD: cfg.threshold <= cfg_wdata[THRESH_BITS-1:0];
        REG_PULSE_WIDTH:      cfg.width     <= cfg_wdata[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                in_valid;
  pulse_item_t         in_item;
  logic [INC_BITS-1:0] in_master;

  // result register
  logic                  out_valid;
  logic [TOTAL_BITS-1:0] out_local;
  logic [TOTAL_BITS-1:0] out_master;
  logic                  out_level;
  logic                  out_started;
  logic [COUNT_BITS-1:0] out_tally;

  // item moves from input register into state and result registers
  logic advance;
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.action    <= action_t'(s_tuser);
      in_item.local_inc <= s_tdata[INC_BITS-1:0];
      in_item.clear     <= s_tdata[2*INC_BITS];
      in_master         <= s_tdata[2*INC_BITS-1:INC_BITS];
    end
  end

  // running totals
  logic [TOTAL_BITS-1:0] local_acc;
  logic [TOTAL_BITS-1:0] master_acc;
  logic [TOTAL_BITS-1:0] local_acc_next;
  logic [TOTAL_BITS-1:0] master_acc_next;
  logic [TOTAL_BITS:0]   local_sum_wide;
  logic [TOTAL_BITS:0]   master_sum_wide;

  assign local_sum_wide  = (TOTAL_BITS+1)'(local_acc) + (TOTAL_BITS+1)'(in_item.local_inc);
  assign master_sum_wide = (TOTAL_BITS+1)'(master_acc) + (TOTAL_BITS+1)'(in_master);

  always_comb begin
    local_acc_next  = local_acc;
    master_acc_next = master_acc;
    if (in_item.action == ACT_ADD) begin
      // carry out of the total means it sticks at full scale
      local_acc_next  = local_sum_wide[TOTAL_BITS] ? TOTAL_MAX
                                                   : local_sum_wide[TOTAL_BITS-1:0];
      master_acc_next = master_sum_wide[TOTAL_BITS] ? TOTAL_MAX
                                                    : master_sum_wide[TOTAL_BITS-1:0];
    end
  end

  // bucket, pulse level, timer and pulse count
  pulse_state_t pulse_state;
  pulse_state_t pulse_state_next;
  logic         pulse_started;

  tap_pulse u_pulse (
    .cfg        (cfg),
    .state      (pulse_state),
    .item       (in_item),
    .state_next (pulse_state_next),
    .started    (pulse_started)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      local_acc   <= '0;
      master_acc  <= '0;
      pulse_state <= '0;
    end else if (advance) begin
      local_acc   <= local_acc_next;
      master_acc  <= master_acc_next;
      pulse_state <= pulse_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_local   <= local_acc_next;
      out_master  <= master_acc_next;
      out_level   <= pulse_state_next.level;
      out_started <= pulse_started;
      out_tally   <= pulse_state_next.tally;
    end
  end

  // totals are shown as 48-bit values: zero extended or truncated
  logic [63:0] out_local_wide;
  logic [63:0] out_master_wide;
  assign out_local_wide  = 64'(out_local);
  assign out_master_wide = 64'(out_master);

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_tally, out_started, out_level,
                     out_master_wide[OUT_SUM_BITS-1:0], out_local_wide[OUT_SUM_BITS-1:0]};

  // a tick item never raises a pulse nor changes the count
  assert property (@(posedge clk) disable iff (rst)
    advance && (in_item.action == ACT_TICK) |=> !out_started &&
      (pulse_state.tally == $past(pulse_state.tally)))
    else $error("tick item changed the pulse count");

  // a raised pulse restarts the timer and counts once
  assert property (@(posedge clk) disable iff (rst)
    advance && pulse_started |=> (pulse_state.elapsed == '0) &&
      (pulse_state.tally == $past(pulse_state.tally) + COUNT_BITS'(1)))
    else $error("pulse start did not restart timer or count");

  // totals never go down outside reset
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (local_acc >= $past(local_acc)) && (master_acc >= $past(master_acc)))
    else $error("running total decreased");

  // an empty input register always takes an item
  assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled while input register empty");

  // a waiting result holds its data
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(out_tally) && $stable(out_local))
    else $error("waiting result changed");

endmodule

`default_nettype wire
